// ----- rtl/arpc_pkg.sv -----
// Shared types, codes and sizes for the ARP cache table.
// No dependencies; used by every module under rtl/.
package arpc_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = 5;

   localparam logic [31:0] TIMEOUT_RESET = 32'd60000;

   // Command codes on req_command.
   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_SWEEP  = 2'd2;

   // Status codes on rsp_status.
   localparam logic [1:0] STS_OK     = 2'd0;
   localparam logic [1:0] STS_MISS   = 2'd1;
   localparam logic [1:0] STS_REJECT = 2'd2;

   // One table row as stored in the entry memory.
   typedef struct packed {
      logic [31:0] key;
      logic [47:0] hw_addr;
      logic [63:0] stamp;
   } entry_type;

   // One result transaction.
   typedef struct packed {
      logic [1:0]       status;
      logic [47:0]      mac_out;
      logic [CNT_W-1:0] removed_count;
      logic [CNT_W-1:0] entries_in_use;
   } rsp_type;

endpackage

// ----- rtl/arpc_mem.sv -----
// Entry memory of the ARP cache: one write port, one read port, registered read data.
// Depends on arpc_pkg for the row type and depth.
module arpc_mem (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [arpc_pkg::IDX_W-1:0] wr_addr,
   input  arpc_pkg::entry_type      wr_data,
   input  logic                     rd_en,
   input  logic [arpc_pkg::IDX_W-1:0] rd_addr,
   output arpc_pkg::entry_type      rd_data
);

   arpc_pkg::entry_type mem_ff [arpc_pkg::ENTRIES];
   arpc_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/arpc_engine.sv -----
// Command sequencer of the ARP cache: scans the entry memory, keeps the valid bits
// and the entry count, and writes back adds. Depends on arpc_pkg and arpc_mem.
module arpc_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic [31:0]         timeout_ms,
   input  logic                start,
   output logic                idle,
   input  logic [1:0]          command,
   input  logic [31:0]         ip_addr,
   input  logic [47:0]         mac_in,
   input  logic [63:0]         time_now,
   input  logic                out_free,
   output logic                res_valid,
   output arpc_pkg::rsp_type   res
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_DONE  = 3'd3;

   localparam int IW = arpc_pkg::IDX_W;
   localparam int CW = arpc_pkg::CNT_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(arpc_pkg::ENTRIES - 1);

   logic [2:0]  state_ff, state_in;
   logic [1:0]  cmd_ff, cmd_in;
   logic [31:0] ip_ff, ip_in;
   logic [47:0] mac_ff, mac_next_in;
   logic [63:0] now_ff, now_in;

   logic [IW-1:0] issue_idx_ff, issue_idx_in;
   logic          cmp_vld_ff, cmp_vld_in;
   logic [IW-1:0] cmp_idx_ff, cmp_idx_in;

   logic          hit_ff, hit_in;
   logic [IW-1:0] hit_idx_ff, hit_idx_in;
   logic [47:0]   hit_mac_ff, hit_mac_in;
   logic          free_ff, free_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;
   logic [CW-1:0] removed_ff, removed_in;

   logic [arpc_pkg::ENTRIES-1:0] valid_ff, valid_in;
   logic [CW-1:0] total_ff, total_in;

   arpc_pkg::entry_type rd_data;
   arpc_pkg::entry_type wr_data;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic          rd_en;

   logic          entry_live;
   logic [63:0]   age;
   logic          add_hit, add_fill;
   arpc_pkg::rsp_type res_c;

   arpc_mem u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (issue_idx_ff),
      .rd_data (rd_data)
   );

   assign rd_en      = (state_ff == ST_SCAN);
   assign entry_live = valid_ff[cmp_idx_ff];
   assign age        = now_ff - rd_data.stamp;

   assign add_hit  = (cmd_ff == arpc_pkg::CMD_ADD) && (ip_ff != 32'd0) && hit_ff;
   assign add_fill = (cmd_ff == arpc_pkg::CMD_ADD) && (ip_ff != 32'd0) && !hit_ff && free_ff;

   assign wr_en        = (state_ff == ST_DONE) && out_free && (add_hit || add_fill);
   assign wr_addr      = add_hit ? hit_idx_ff : free_idx_ff;
   assign wr_data      = '{key: ip_ff, hw_addr: mac_ff, stamp: now_ff};

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      ip_in        = ip_ff;
      mac_next_in  = mac_ff;
      now_in       = now_ff;
      issue_idx_in = issue_idx_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = issue_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_mac_in   = hit_mac_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      removed_in   = removed_ff;
      valid_in     = valid_ff;
      total_in     = total_ff;

      // Compare stage: the row read last cycle is checked here.
      if (cmp_vld_ff) begin
         if (cmd_ff == arpc_pkg::CMD_SWEEP) begin
            if (entry_live && (age >= {32'd0, timeout_ms})) begin
               valid_in[cmp_idx_ff] = 1'b0;
               removed_in           = removed_ff + CW'(1);
               if (total_ff != '0) begin
                  total_in = total_ff - CW'(1);
               end
            end
         end else begin
            if (entry_live && (rd_data.key == ip_ff) && !hit_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = cmp_idx_ff;
               hit_mac_in = rd_data.hw_addr;
            end
            if (!entry_live && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = cmp_idx_ff;
            end
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in       = command;
               ip_in        = ip_addr;
               mac_next_in  = mac_in;
               now_in       = time_now;
               issue_idx_in = '0;
               hit_in       = 1'b0;
               free_in      = 1'b0;
               removed_in   = '0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmp_vld_in   = 1'b1;
            issue_idx_in = issue_idx_ff + IW'(1);
            if (issue_idx_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               if (add_fill) begin
                  valid_in[free_idx_ff] = 1'b1;
                  total_in              = total_ff + CW'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      res_c.status         = arpc_pkg::STS_OK;
      res_c.mac_out        = 48'd0;
      res_c.removed_count  = '0;
      res_c.entries_in_use = total_ff;
      case (cmd_ff)
         arpc_pkg::CMD_ADD: begin
            if (add_fill) begin
               res_c.entries_in_use = total_ff + CW'(1);
            end else if (!add_hit) begin
               res_c.status = arpc_pkg::STS_REJECT;
            end
         end
         arpc_pkg::CMD_LOOKUP: begin
            if ((ip_ff != 32'd0) && hit_ff) begin
               res_c.mac_out = hit_mac_ff;
            end else begin
               res_c.status = arpc_pkg::STS_MISS;
            end
         end
         arpc_pkg::CMD_SWEEP: begin
            res_c.removed_count = removed_ff;
         end
         default: begin
            res_c.status = arpc_pkg::STS_OK;
         end
      endcase
   end

   assign idle      = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res       = res_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cmp_vld_ff <= 1'b0;
         valid_ff   <= '0;
         total_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= cmp_vld_in;
         valid_ff   <= valid_in;
         total_ff   <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      ip_ff        <= ip_in;
      mac_ff       <= mac_next_in;
      now_ff       <= now_in;
      issue_idx_ff <= issue_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      hit_mac_ff   <= hit_mac_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      removed_ff   <= removed_in;
   end

endmodule

// ----- rtl/arp_cache_table.sv -----
// Top level of the ARP cache table: timeout register, request intake and result register.
// Depends on arpc_pkg and arpc_engine.
//
// The block maps IPv4 addresses to 48-bit MAC addresses in a table of
// arpc_pkg::ENTRIES rows. A request transaction on req_* carries a command
// (add or update, lookup, age sweep), an address, a MAC and the current time.
// Each request yields exactly one response transaction on rsp_*.
// The timeout for age sweeps is written through csr_*, which is always ready;
// it should only be written while no request is in flight.
//
// Every command reads all rows of the entry memory once, one row per cycle,
// through the single read port of that memory. The block takes a new request
// only while the engine is idle, so it cannot accept the next request before
// it has handed the result of the last one to the output register.
// An add writes its row back in the last cycle, so the next scan always sees it.
//
// The response sits in an output register. While the receiver stalls, the
// block still accepts the next request and scans for it; it only waits before
// handing over that second response. Reset clears all valid bits, the entry
// count and the response valid flag, and loads the timeout with 60000 ms; no
// clearing pass over the memory is needed.
module arp_cache_table (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_timeout_ms,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_ip_addr,
   input  logic [47:0] req_mac_in,
   input  logic [63:0] req_time_now,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [47:0] rsp_mac_out,
   output logic [4:0]  rsp_removed_count,
   output logic [4:0]  rsp_entries_in_use
);

   logic [31:0] timeout_ff, timeout_in;

   logic              rsp_valid_ff, rsp_valid_in;
   arpc_pkg::rsp_type rsp_ff, rsp_in;

   logic              eng_idle;
   logic              eng_res_valid;
   arpc_pkg::rsp_type eng_res;
   logic              out_free;

   // Configuration writes are never back-pressured.
   assign csr_ready  = 1'b1;
   assign timeout_in = (csr_valid && csr_ready) ? csr_timeout_ms : timeout_ff;

   // The output register can take a new response when it is empty or being drained.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = eng_idle;

   arpc_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .timeout_ms (timeout_ff),
      .start      (req_valid && req_ready),
      .idle       (eng_idle),
      .command    (req_command),
      .ip_addr    (req_ip_addr),
      .mac_in     (req_mac_in),
      .time_now   (req_time_now),
      .out_free   (out_free),
      .res_valid  (eng_res_valid),
      .res        (eng_res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (eng_res_valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = eng_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= arpc_pkg::TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         timeout_ff   <= timeout_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_mac_out        = rsp_ff.mac_out;
   assign rsp_removed_count  = rsp_ff.removed_count;
   assign rsp_entries_in_use = rsp_ff.entries_in_use;

endmodule
